/* hw/rtl/p1305_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1305_pkg
// Shared types, operation codes and constants of the Poly1305 MAC block.
// ----------------------------------------------------------------------------
package p1305_pkg;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
        logic [4:0]  byte_count;
        logic        last_block;
    } t_in_word;

    typedef struct packed {
        logic [63:0] tag_low;
        logic [63:0] tag_high;
    } t_out_word;

    // datapath operations
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_RED1 = 3'd3;
    localparam logic [2:0] OP_RED2 = 3'd4;
    localparam logic [2:0] OP_RED3 = 3'd5;
    localparam logic [2:0] OP_RED4 = 3'd6;
    localparam logic [2:0] OP_TAG  = 3'd7;

    // register indexes
    localparam logic [1:0] CFG_R_LOW  = 2'd0;
    localparam logic [1:0] CFG_R_HIGH = 2'd1;
    localparam logic [1:0] CFG_S_LOW  = 2'd2;
    localparam logic [1:0] CFG_S_HIGH = 2'd3;

    // 32-bit limbs: operand has five, key r has four
    localparam logic [2:0] LIMB_A_LAST = 3'd4;
    localparam logic [1:0] LIMB_R_LAST = 2'd3;

    localparam logic [4:0]   MAX_BYTES  = 5'd16;
    localparam logic [63:0]  CLAMP_LOW  = 64'h0ffffffc0fffffff;
    localparam logic [63:0]  CLAMP_HIGH = 64'h0ffffffc0ffffffc;
    localparam logic [129:0] PRIME      = {2'b11, 128'hffffffff_ffffffff_ffffffff_fffffffb};

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] ai;
        logic [1:0] rj;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic last;
    } t_stat;

endpackage

/* hw/rtl/p1305_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1305_dp
// Datapath: key registers, accumulator, limb multiplier with product
// register, modular reduction and tag register.
// ----------------------------------------------------------------------------
module p1305_dp
    import p1305_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  t_in_word    i_in_data,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output t_out_word   o_tag
);

    logic [63:0]  r_rl, r_rh, r_sl, r_sh;
    logic [129:0] r_acc;
    logic [130:0] r_a;
    logic [130:0] r_red;
    logic [31:0]  r_p [8];
    logic [31:0]  r_carry;
    logic [127:0] r_tag;

    logic [4:0]   cnt_eff;
    logic [127:0] blk;
    logic [128:0] n_val;
    logic [127:0] r_clamp;
    logic [31:0]  a_limb;
    logic [31:0]  r_limb;
    logic [31:0]  carry_in;
    logic [2:0]   k;
    logic [63:0]  prod;
    logic [63:0]  tsum;
    logic [255:0] p_flat;
    logic [125:0] p_hi;
    logic [130:0] v_sub;

    assign o_stat.empty = (i_in_data.byte_count == 5'd0);
    assign o_stat.last  = i_in_data.last_block;

    assign cnt_eff = (i_in_data.byte_count > MAX_BYTES) ? MAX_BYTES : i_in_data.byte_count;
    assign blk     = {i_in_data.block_high, i_in_data.block_low};

    always_comb begin
        n_val = '0;
        for (int b = 0; b < 16; b++) begin
            n_val[8*b +: 8] = (5'(b) < cnt_eff) ? blk[8*b +: 8] : 8'h00;
        end
        for (int b = 0; b <= 16; b++) begin
            if (cnt_eff == 5'(b)) begin
                n_val[8*b] = 1'b1;
            end
        end
    end

    assign r_clamp = {r_rh & CLAMP_HIGH, r_rl & CLAMP_LOW};

    always_comb begin
        case (i_cmd.ai)
            3'd0:    a_limb = r_a[31:0];
            3'd1:    a_limb = r_a[63:32];
            3'd2:    a_limb = r_a[95:64];
            3'd3:    a_limb = r_a[127:96];
            3'd4:    a_limb = {29'd0, r_a[130:128]};
            default: a_limb = '0;
        endcase
    end

    assign r_limb   = r_clamp[32*i_cmd.rj +: 32];
    assign k        = i_cmd.ai + {1'b0, i_cmd.rj};
    assign carry_in = (i_cmd.ai == 3'd0) ? 32'd0 : r_carry;
    assign prod     = a_limb * r_limb;
    assign tsum     = prod + {32'd0, r_p[k]} + {32'd0, carry_in};

    always_comb begin
        for (int w = 0; w < 8; w++) begin
            p_flat[32*w +: 32] = r_p[w];
        end
    end

    assign p_hi  = p_flat[255:130];
    assign v_sub = {1'b0, r_red[129:0]} + 131'd5;

    // key registers and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rl  <= '0;
            r_rh  <= '0;
            r_sl  <= '0;
            r_sh  <= '0;
            r_acc <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_R_LOW:  r_rl <= i_cfg_data;
                    CFG_R_HIGH: r_rh <= i_cfg_data;
                    CFG_S_LOW:  r_sl <= i_cfg_data;
                    CFG_S_HIGH: r_sh <= i_cfg_data;
                    default:    r_rl <= r_rl;
                endcase
            end
            if (i_cmd.op == OP_RED4) begin
                r_acc <= v_sub[130] ? v_sub[129:0] : r_red[129:0];
            end else if (i_cmd.op == OP_TAG) begin
                r_acc <= '0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_a <= {1'b0, r_acc} + {2'b00, n_val};
                for (int w = 0; w < 8; w++) begin
                    r_p[w] <= '0;
                end
            end
            OP_MUL: begin
                r_carry <= tsum[63:32];
                for (int w = 0; w < 8; w++) begin
                    if (3'(w) == k) begin
                        r_p[w] <= tsum[31:0];
                    end else if (i_cmd.ai == LIMB_A_LAST && 4'(w) == {1'b0, k} + 4'd1) begin
                        r_p[w] <= tsum[63:32];
                    end
                end
            end
            OP_RED1: r_red <= {3'd0, p_hi, 2'b00} + {5'd0, p_hi};
            OP_RED2: r_red <= r_red + {1'b0, p_flat[129:0]};
            OP_RED3: r_red <= {1'b0, r_red[129:0]} + (r_red[130] ? 131'd5 : 131'd0);
            OP_TAG:  r_tag <= r_acc[127:0] + {r_sh, r_sl};
            default: r_carry <= r_carry;
        endcase
    end

    assign o_tag.tag_low  = r_tag[63:0];
    assign o_tag.tag_high = r_tag[127:64];

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc < PRIME)
        else $error("accumulator not reduced");

    a_red3_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_RED3) |=> !r_red[130])
        else $error("partial reduction overflow");

    a_prod_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_MUL && i_cmd.ai == LIMB_A_LAST && i_cmd.rj == LIMB_R_LAST)
        |=> !p_flat[255])
        else $error("product exceeds bound");

endmodule

/* hw/rtl/p1305_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1305_ctrl
// Controller: sequences load, limb products, reduction and tag steps, and
// owns the input ready and output valid.
// ----------------------------------------------------------------------------
module p1305_ctrl
    import p1305_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_out_valid,
    input  logic  i_out_ready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RED1 = 3'd2;
    localparam logic [2:0] S_RED2 = 3'd3;
    localparam logic [2:0] S_RED3 = 3'd4;
    localparam logic [2:0] S_RED4 = 3'd5;
    localparam logic [2:0] S_TAG  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_i, n_i;
    logic [1:0] r_j, n_j;
    logic       r_last, n_last;
    logic       r_out_vld, n_out_vld;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_last    = r_last;
        n_out_vld = r_out_vld & ~i_out_ready;
        o_cmd.op  = OP_NONE;
        o_cmd.ai  = r_i;
        o_cmd.rj  = r_j;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_last   = i_stat.last;
                    n_i      = 3'd0;
                    n_j      = 2'd0;
                    if (i_stat.empty) begin
                        n_state = i_stat.last ? S_TAG : S_IDLE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                if (r_i == LIMB_A_LAST) begin
                    n_i = 3'd0;
                    if (r_j == LIMB_R_LAST) begin
                        n_state = S_RED1;
                    end else begin
                        n_j = r_j + 2'd1;
                    end
                end else begin
                    n_i = r_i + 3'd1;
                end
            end
            S_RED1: begin
                o_cmd.op = OP_RED1;
                n_state  = S_RED2;
            end
            S_RED2: begin
                o_cmd.op = OP_RED2;
                n_state  = S_RED3;
            end
            S_RED3: begin
                o_cmd.op = OP_RED3;
                n_state  = S_RED4;
            end
            S_RED4: begin
                o_cmd.op = OP_RED4;
                n_state  = r_last ? S_TAG : S_IDLE;
            end
            S_TAG: begin
                // hold until the output register is free
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.op  = OP_TAG;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_i       <= '0;
            r_j       <= '0;
            r_last    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_i       <= n_i;
            r_j       <= n_j;
            r_last    <= n_last;
            r_out_vld <= n_out_vld;
        end
    end

    a_limb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_i <= LIMB_A_LAST))
        else $error("limb index out of range");

    a_tag_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_TAG) |-> (!r_out_vld || i_out_ready))
        else $error("tag overwrites pending word");

    a_start_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_stat.empty)
        |=> (r_state == S_MUL && r_i == 3'd0 && r_j == 2'd0))
        else $error("block did not start multiply");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED4 && !r_last) |=> o_in_ready)
        else $error("no return to idle");

endmodule

/* hw/rtl/poly1305_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly1305_mac
// Poly1305 one-time authenticator, one message block per input word.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one block of up
// to 16 little-endian bytes with its byte count and last flag. Output
// channel (o_out_valid / i_out_ready / o_out_data) gives one 128-bit tag per
// message, after the block marked last. Keys r and s are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while
// the block is idle, as the block itself does not enforce it. A non-empty
// block is loaded, then takes its 32x32 limb products on the single
// multiplier and then the reduction steps. An empty block skips the
// products and reduction. A last block adds a tag step, held while the
// output register is full. A tag waiting there does not block new input
// words; only the next tag waits for it, so a stalled receiver stalls at
// most one tag. Reset clears keys, accumulator and control state.
// ----------------------------------------------------------------------------
module poly1305_mac
    import p1305_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    p1305_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    p1305_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_tag      (o_out_data)
    );

endmodule
